/* rtl/core/bpc_pkg.sv */
package bpc_pkg;

  localparam int unsigned DIV_W = 32;
  localparam int unsigned TAG_W = 40;

  localparam logic [1:0] CFG_CAL_A = 2'd0;
  localparam logic [1:0] CFG_CAL_B = 2'd1;
  localparam logic [1:0] CFG_CAL_C = 2'd2;
  localparam logic [1:0] CFG_OSS   = 2'd3;

  localparam logic signed [29:0] T_OFS     = 30'sd4000;
  localparam logic signed [29:0] T_RND     = 30'sd8;
  localparam logic signed [19:0] U_OFS     = 20'sd32768;
  localparam logic [15:0]        P_SCALE   = 16'd50000;
  localparam logic [11:0]        P_C1      = 12'd3038;
  localparam logic signed [15:0] P_C2      = -16'sd7357;
  localparam logic signed [17:0] P_C3      = 18'sd3791;
  localparam logic signed [31:0] P_MAX     = 32'sd131071;

  typedef struct packed {
    logic             vld;
    logic [DIV_W-1:0] dvd;
    logic [DIV_W-1:0] dvs;
    logic [TAG_W-1:0] tag;
  } div_req_t;

  typedef struct packed {
    logic             vld;
    logic [DIV_W-1:0] quo;
    logic [TAG_W-1:0] tag;
  } div_rsp_t;

  typedef struct packed {
    logic        fault;
    logic [16:0] press;
    logic [15:0] temp;
  } res_t;

endpackage

/* rtl/core/bpc_div.sv */
module bpc_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  bpc_pkg::div_req_t  req_i,
  output bpc_pkg::div_rsp_t  rsp_o
);

  localparam int unsigned W = bpc_pkg::DIV_W;
  localparam int unsigned T = bpc_pkg::TAG_W;

  logic         vld_q [W];
  logic [W-1:0] rem_q [W];
  logic [W-1:0] qd_q  [W];
  logic [W-1:0] dvs_q [W];
  logic [T-1:0] tag_q [W];

  for (genvar g = 0; g < W; g++) begin : g_stage
    logic         vin;
    logic [W-1:0] rin;
    logic [W-1:0] qin;
    logic [W-1:0] din;
    logic [T-1:0] tin;
    logic [W:0]   trial;
    logic         ge;

    if (g == 0) begin : g_first
      assign vin = req_i.vld;
      assign rin = '0;
      assign qin = req_i.dvd;
      assign din = req_i.dvs;
      assign tin = req_i.tag;
    end else begin : g_next
      assign vin = vld_q[g-1];
      assign rin = rem_q[g-1];
      assign qin = qd_q[g-1];
      assign din = dvs_q[g-1];
      assign tin = tag_q[g-1];
    end

    assign trial = {rin, qin[W-1]};
    assign ge    = trial >= {1'b0, din};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[g] <= 1'b0;
      end else if (en_i) begin
        vld_q[g] <= vin;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[g] <= ge ? W'(trial - {1'b0, din}) : trial[W-1:0];
        qd_q[g]  <= {qin[W-2:0], ge};
        dvs_q[g] <= din;
        tag_q[g] <= tin;
      end
    end
  end

  assign rsp_o.vld = vld_q[W-1] & (rem_q[W-1] == rem_q[W-1]);
  assign rsp_o.quo = qd_q[W-1];
  assign rsp_o.tag = tag_q[W-1];

endmodule

/* rtl/core/bpc_obuf.sv */
module bpc_obuf (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_vld_i,
  input  bpc_pkg::res_t  in_i,
  input  logic           rdy_i,
  output logic           vld_o,
  output bpc_pkg::res_t  out_o,
  output logic           en_o
);

  logic          out_vld_q;
  logic          skid_vld_q;
  bpc_pkg::res_t out_q;
  bpc_pkg::res_t skid_q;
  logic          take;

  assign en_o  = !skid_vld_q;
  assign take  = !out_vld_q || rdy_i;
  assign vld_o = out_vld_q;
  assign out_o = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (take) begin
      if (skid_vld_q) begin
        out_vld_q  <= 1'b1;
        skid_vld_q <= 1'b0;
      end else begin
        out_vld_q <= in_vld_i;
      end
    end else if (in_vld_i && !skid_vld_q) begin
      skid_vld_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      out_q <= skid_vld_q ? skid_q : in_i;
    end else if (!skid_vld_q) begin
      skid_q <= in_i;
    end
  end

endmodule

/* rtl/core/barometric_pressure_compensation_unit.sv */
// word path: a, b, temp divider, d to l, press divider, m to o, output buffer
// throughput: one word per cycle unless the output stalls, a fully pipelined
// datapath with two 32-stage restoring dividers (one quotient bit per stage)
// a stalled output parks one word in a skid stage, then the whole pipe holds
// reset: asynchronous active-low, clears valid bits and calibration registers to zero
module barometric_pressure_compensation_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [39:0] s_axis_tdata_i,   // raw_temp[15:0], raw_press[34:16]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [39:0] m_axis_tdata_o,   // temp_tenths[15:0], press_pa[32:16]
  output logic        m_axis_tuser_o,   // calc_fault
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [63:0] cfg_wdata_i
);

  logic [63:0] cal_a_q;
  logic [63:0] cal_b_q;
  logic [31:0] cal_c_q;
  logic [1:0]  oss_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cal_a_q <= '0;
      cal_b_q <= '0;
      cal_c_q <= '0;
      oss_q   <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        bpc_pkg::CFG_CAL_A: cal_a_q <= cfg_wdata_i;
        bpc_pkg::CFG_CAL_B: cal_b_q <= cfg_wdata_i;
        bpc_pkg::CFG_CAL_C: cal_c_q <= cfg_wdata_i[31:0];
        bpc_pkg::CFG_OSS:   oss_q   <= cfg_wdata_i[1:0];
        default: ;
      endcase
    end
  end

  logic signed [15:0] ac1, ac2, ac3, b1, b2, mc, md;
  logic        [15:0] ac4, ac5, ac6;

  assign ac1 = $signed(cal_a_q[63:48]);
  assign ac2 = $signed(cal_a_q[47:32]);
  assign ac3 = $signed(cal_a_q[31:16]);
  assign ac4 = cal_a_q[15:0];
  assign ac5 = cal_b_q[63:48];
  assign ac6 = cal_b_q[47:32];
  assign b1  = $signed(cal_b_q[31:16]);
  assign b2  = $signed(cal_b_q[15:0]);
  assign mc  = $signed(cal_c_q[31:16]);
  assign md  = $signed(cal_c_q[15:0]);

  logic en;

  // valid bits
  logic a_vld_q, b_vld_q, d_vld_q, e_vld_q, f_vld_q, g_vld_q, h_vld_q;
  logic i_vld_q, j_vld_q, k_vld_q, l_vld_q, m_vld_q, n_vld_q, o_vld_q;

  bpc_pkg::div_req_t div1_req, div2_req;
  bpc_pkg::div_rsp_t div1_rsp, div2_rsp;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0; b_vld_q <= 1'b0; d_vld_q <= 1'b0; e_vld_q <= 1'b0;
      f_vld_q <= 1'b0; g_vld_q <= 1'b0; h_vld_q <= 1'b0; i_vld_q <= 1'b0;
      j_vld_q <= 1'b0; k_vld_q <= 1'b0; l_vld_q <= 1'b0; m_vld_q <= 1'b0;
      n_vld_q <= 1'b0; o_vld_q <= 1'b0;
    end else if (en) begin
      a_vld_q <= s_axis_tvalid_i;
      b_vld_q <= a_vld_q;
      d_vld_q <= div1_rsp.vld;
      e_vld_q <= d_vld_q;
      f_vld_q <= e_vld_q;
      g_vld_q <= f_vld_q;
      h_vld_q <= g_vld_q;
      i_vld_q <= h_vld_q;
      j_vld_q <= i_vld_q;
      k_vld_q <= j_vld_q;
      l_vld_q <= k_vld_q;
      m_vld_q <= div2_rsp.vld;
      n_vld_q <= m_vld_q;
      o_vld_q <= n_vld_q;
    end
  end

  // stage a: input capture
  logic [15:0] a_ut_q;
  logic [18:0] a_up_q;

  // stage b: (ut - ac6) * ac5
  logic signed [16:0] b_dif;
  logic signed [33:0] b_prod;
  logic [31:0]        b_p1_q;
  logic [18:0]        b_up_q;

  assign b_dif  = $signed({1'b0, a_ut_q}) - $signed({1'b0, ac6});
  assign b_prod = b_dif * $signed({1'b0, ac5});

  // temperature divider operands
  logic signed [16:0] c_x1;
  logic signed [17:0] c_den;
  logic [17:0]        c_dmag;
  logic [15:0]        c_mcmag;
  logic               c_neg;

  assign c_x1    = $signed(b_p1_q[31:15]);
  assign c_den   = 18'(c_x1) + 18'(md);
  assign c_dmag  = c_den[17] ? 18'(-c_den) : 18'(c_den);
  assign c_mcmag = mc[15] ? 16'(-mc) : 16'(mc);
  assign c_neg   = c_den[17] ^ mc[15];

  assign div1_req.vld = b_vld_q;
  assign div1_req.dvd = 32'({c_mcmag, 11'b0});
  assign div1_req.dvs = 32'(c_dmag);
  assign div1_req.tag = bpc_pkg::TAG_W'({c_x1, c_neg, c_den == 18'sd0, b_up_q});

  bpc_div u_div_temp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .req_i  (div1_req),
    .rsp_o  (div1_rsp)
  );

  // stage d: b5
  logic [27:0]        d_q;
  logic signed [27:0] d_x2;
  logic signed [16:0] d_x1;
  logic signed [28:0] d_b5_q;
  logic [18:0]        d_up_q;
  logic               d_flt_q;

  assign d_q  = {1'b0, div1_rsp.quo[26:0]};
  assign d_x2 = div1_rsp.tag[20] ? -$signed(d_q) : $signed(d_q);
  assign d_x1 = $signed(div1_rsp.tag[37:21]);

  // stage e: b6 and saturated temperature
  logic signed [29:0] e_tr;
  logic signed [25:0] e_ts;
  logic [15:0]        e_t;
  logic signed [29:0] e_b6_q;
  logic [15:0]        e_t_q;
  logic [18:0]        e_up_q;
  logic               e_flt_q;

  assign e_tr = 30'(d_b5_q) + bpc_pkg::T_RND;
  assign e_ts = e_tr[29:4];

  always_comb begin
    if (e_ts > 26'sd32767) begin
      e_t = 16'h7fff;
    end else if (e_ts < -26'sd32768) begin
      e_t = 16'h8000;
    end else begin
      e_t = e_ts[15:0];
    end
  end

  // stage f: products of b6
  logic signed [59:0] f_sq;
  logic signed [45:0] f_m2, f_m3;
  logic [31:0]        f_sq_q, f_m2_q, f_m3_q;
  logic [15:0]        f_t_q;
  logic [18:0]        f_up_q;
  logic               f_flt_q;

  assign f_sq = e_b6_q * e_b6_q;
  assign f_m2 = ac2 * e_b6_q;
  assign f_m3 = ac3 * e_b6_q;

  // stage g: products of b6^2 >> 12
  logic signed [19:0] g_bsq;
  logic signed [35:0] g_k2, g_k1;
  logic [31:0]        g_k2_q, g_k1_q, g_m2_q, g_m3_q;
  logic [15:0]        g_t_q;
  logic [18:0]        g_up_q;
  logic               g_flt_q;

  assign g_bsq = $signed(f_sq_q[31:12]);
  assign g_k2  = b2 * g_bsq;
  assign g_k1  = b1 * g_bsq;

  // stage h: x3 terms
  logic signed [20:0] h_a, h_b, h_sum;
  logic signed [18:0] h_c;
  logic signed [15:0] h_e;
  logic signed [21:0] h_x3t_q;
  logic signed [18:0] h_x3p_q;
  logic [15:0]        h_t_q;
  logic [18:0]        h_up_q;
  logic               h_flt_q;

  assign h_a   = $signed(g_k2_q[31:11]);
  assign h_b   = $signed(g_m2_q[31:11]);
  assign h_c   = $signed(g_m3_q[31:13]);
  assign h_e   = $signed(g_k1_q[31:16]);
  assign h_sum = 21'(h_c) + 21'(h_e) + 21'sd2;

  // stage i: scaled b3 numerator and b4 factor
  logic signed [22:0] i_s;
  logic signed [26:0] i_v;
  logic signed [19:0] i_w;
  logic signed [26:0] i_v_q;
  logic [31:0]        i_u_q;
  logic [15:0]        i_t_q;
  logic [18:0]        i_up_q;
  logic               i_flt_q;

  assign i_s = 23'($signed({ac1, 2'b00})) + 23'(h_x3t_q);
  assign i_v = (27'(i_s) <<< oss_q) + 27'sd2;
  assign i_w = 20'(h_x3p_q) + bpc_pkg::U_OFS;

  // stage j: b3 and b4
  logic signed [27:0] j_vr;
  logic [47:0]        j_pr;
  logic signed [24:0] j_b3_q;
  logic [16:0]        j_b4_q;
  logic [15:0]        j_t_q;
  logic [18:0]        j_up_q;
  logic               j_flt_q;

  assign j_vr = 28'(i_v_q) + (i_v_q[26] ? 28'sd3 : 28'sd0);
  assign j_pr = ac4 * i_u_q;

  // stage k: up - b3
  logic [31:0] k_b3x;
  logic [31:0] k_df_q;
  logic [16:0] k_b4_q;
  logic [15:0] k_t_q;
  logic        k_flt_q;

  assign k_b3x = 32'(j_b3_q);

  // stage l: b7
  logic [15:0] l_sc;
  logic [47:0] l_pr;
  logic [31:0] l_b7_q;
  logic [16:0] l_b4_q;
  logic [15:0] l_t_q;
  logic        l_flt_q;

  assign l_sc = bpc_pkg::P_SCALE >> oss_q;
  assign l_pr = k_df_q * l_sc;

  assign div2_req.vld = l_vld_q;
  assign div2_req.dvd = l_b7_q[31] ? l_b7_q : {l_b7_q[30:0], 1'b0};
  assign div2_req.dvs = 32'(l_b4_q);
  assign div2_req.tag = bpc_pkg::TAG_W'({l_t_q, l_flt_q | (l_b4_q == '0), l_b7_q[31]});

  bpc_div u_div_press (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .req_i  (div2_req),
    .rsp_o  (div2_rsp)
  );

  // stage m: p and its products
  logic [31:0]        m_qf;
  logic signed [23:0] m_a;
  logic signed [47:0] m_sqa;
  logic signed [47:0] m_m7;
  logic [31:0]        m_p_q, m_sq_q, m_m7_q;
  logic [15:0]        m_t_q;
  logic               m_flt_q;

  assign m_qf  = div2_rsp.tag[0] ? {div2_rsp.quo[30:0], 1'b0} : div2_rsp.quo;
  assign m_a   = $signed(m_qf[31:8]);
  assign m_sqa = m_a * m_a;
  assign m_m7  = $signed(m_qf) * bpc_pkg::P_C2;

  // stage n
  logic [43:0] n_k;
  logic [31:0] n_k_q, n_p_q, n_m7_q;
  logic [15:0] n_t_q;
  logic        n_flt_q;

  assign n_k = m_sq_q * bpc_pkg::P_C1;

  // stage o
  logic signed [17:0] o_s;
  logic signed [17:0] o_s_q;
  logic [31:0]        o_p_q;
  logic [15:0]        o_t_q;
  logic               o_flt_q;

  assign o_s = 18'($signed(n_k_q[31:16])) + 18'($signed(n_m7_q[31:16])) + bpc_pkg::P_C3;

  // final pressure and saturation
  logic signed [31:0] p_f;
  logic [16:0]        p_sat;
  bpc_pkg::res_t      p_res;

  assign p_f = $signed(o_p_q) + 32'($signed(o_s_q[17:4]));

  always_comb begin
    if (p_f[31]) begin
      p_sat = '0;
    end else if (p_f > bpc_pkg::P_MAX) begin
      p_sat = '1;
    end else begin
      p_sat = p_f[16:0];
    end
    p_res.fault = o_flt_q;
    p_res.press = o_flt_q ? '0 : p_sat;
    p_res.temp  = o_flt_q ? '0 : o_t_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_ut_q  <= s_axis_tdata_i[15:0];
      a_up_q  <= s_axis_tdata_i[34:16];

      b_p1_q  <= b_prod[31:0];
      b_up_q  <= a_up_q;

      d_b5_q  <= 29'(d_x1) + 29'(d_x2);
      d_up_q  <= div1_rsp.tag[18:0];
      d_flt_q <= div1_rsp.tag[19];

      e_b6_q  <= 30'(d_b5_q) - bpc_pkg::T_OFS;
      e_t_q   <= e_t;
      e_up_q  <= d_up_q;
      e_flt_q <= d_flt_q;

      f_sq_q  <= f_sq[31:0];
      f_m2_q  <= f_m2[31:0];
      f_m3_q  <= f_m3[31:0];
      f_t_q   <= e_t_q;
      f_up_q  <= e_up_q;
      f_flt_q <= e_flt_q;

      g_k2_q  <= g_k2[31:0];
      g_k1_q  <= g_k1[31:0];
      g_m2_q  <= f_m2_q;
      g_m3_q  <= f_m3_q;
      g_t_q   <= f_t_q;
      g_up_q  <= f_up_q;
      g_flt_q <= f_flt_q;

      h_x3t_q <= 22'(h_a) + 22'(h_b);
      h_x3p_q <= h_sum[20:2];
      h_t_q   <= g_t_q;
      h_up_q  <= g_up_q;
      h_flt_q <= g_flt_q;

      i_v_q   <= i_v;
      i_u_q   <= 32'(i_w);
      i_t_q   <= h_t_q;
      i_up_q  <= h_up_q;
      i_flt_q <= h_flt_q;

      j_b3_q  <= j_vr[26:2];
      j_b4_q  <= j_pr[31:15];
      j_t_q   <= i_t_q;
      j_up_q  <= i_up_q;
      j_flt_q <= i_flt_q;

      k_df_q  <= {13'b0, j_up_q} - k_b3x;
      k_b4_q  <= j_b4_q;
      k_t_q   <= j_t_q;
      k_flt_q <= j_flt_q;

      l_b7_q  <= l_pr[31:0];
      l_b4_q  <= k_b4_q;
      l_t_q   <= k_t_q;
      l_flt_q <= k_flt_q;

      m_p_q   <= m_qf;
      m_sq_q  <= m_sqa[31:0];
      m_m7_q  <= m_m7[31:0];
      m_t_q   <= div2_rsp.tag[17:2];
      m_flt_q <= div2_rsp.tag[1];

      n_k_q   <= n_k[31:0];
      n_p_q   <= m_p_q;
      n_m7_q  <= m_m7_q;
      n_t_q   <= m_t_q;
      n_flt_q <= m_flt_q;

      o_s_q   <= o_s;
      o_p_q   <= n_p_q;
      o_t_q   <= n_t_q;
      o_flt_q <= n_flt_q;
    end
  end

  bpc_pkg::res_t out_res;

  bpc_obuf u_obuf (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_vld_i (o_vld_q),
    .in_i     (p_res),
    .rdy_i    (m_axis_tready_i),
    .vld_o    (m_axis_tvalid_o),
    .out_o    (out_res),
    .en_o     (en)
  );

  assign s_axis_tready_o = en;
  assign m_axis_tdata_o  = {7'b0, out_res.press, out_res.temp};
  assign m_axis_tuser_o  = out_res.fault;

  a_stall_has_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> m_axis_tvalid_o)
    else $error("pipe stalled with no word on the output");

  a_fault_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o |-> m_axis_tdata_o == 40'd0)
    else $error("fault word carries nonzero data");

  a_stall_release: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o && m_axis_tready_i |=> s_axis_tready_o)
    else $error("skid stage did not drain");

endmodule
